FILE: rtl/dlx_instruction_execute_assert.svh
// assertion helpers for the execute unit, sampled on clk and quiet in reset
`ifndef DLX_INSTRUCTION_EXECUTE_ASSERT_SVH
`define DLX_INSTRUCTION_EXECUTE_ASSERT_SVH

// same-cycle implication
`define DLXE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DLXE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/dlxe_pkg.sv
`timescale 1ns / 1ps

package dlxe_pkg;

  localparam int unsigned NUM_REGS  = 32;
  localparam int unsigned NUM_BANKS = 4;

  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 56;

  typedef logic [5:0] op_t;

  localparam op_t OP_LW   = 6'd0;
  localparam op_t OP_SW   = 6'd1;
  localparam op_t OP_LB   = 6'd2;
  localparam op_t OP_SB   = 6'd3;
  localparam op_t OP_JR   = 6'd4;
  localparam op_t OP_BEQZ = 6'd5;
  localparam op_t OP_BNEZ = 6'd6;
  localparam op_t OP_ADDI = 6'd7;
  localparam op_t OP_SUBI = 6'd8;
  localparam op_t OP_ANDI = 6'd9;
  localparam op_t OP_ORI  = 6'd10;
  localparam op_t OP_XORI = 6'd11;
  localparam op_t OP_SGEI = 6'd12;
  localparam op_t OP_SEQI = 6'd13;
  localparam op_t OP_SNEI = 6'd14;
  localparam op_t OP_SLTI = 6'd15;
  localparam op_t OP_SGTI = 6'd16;
  localparam op_t OP_SLEI = 6'd17;
  localparam op_t OP_SLLI = 6'd18;
  localparam op_t OP_SRLI = 6'd19;
  localparam op_t OP_ADD  = 6'd20;
  localparam op_t OP_SUB  = 6'd21;
  localparam op_t OP_AND  = 6'd22;
  localparam op_t OP_OR   = 6'd23;
  localparam op_t OP_XOR  = 6'd24;
  localparam op_t OP_SEQ  = 6'd25;
  localparam op_t OP_SNE  = 6'd26;
  localparam op_t OP_SLT  = 6'd27;
  localparam op_t OP_SGT  = 6'd28;
  localparam op_t OP_SLE  = 6'd29;
  localparam op_t OP_SGE  = 6'd30;
  localparam op_t OP_HALT = 6'd31;
  localparam op_t OP_OUT  = 6'd32;

  // byte memory access, addr is the unwrapped byte address
  typedef struct packed {
    logic        rd;
    logic        wr;
    logic        word;
    logic [31:0] addr;
    logic [31:0] wdata;
  } mem_req_t;

endpackage

FILE: rtl/dlxe_bmem.sv
`timescale 1ns / 1ps

module dlxe_bmem
  import dlxe_pkg::*;
#(
  parameter int unsigned MEM_BYTES
) (
  input  logic        clk,
  input  mem_req_t    req,
  output logic [31:0] rdata
);

  localparam int unsigned AW   = $clog2(MEM_BYTES);
  localparam int unsigned RW   = AW - 2;
  localparam int unsigned ROWS = MEM_BYTES / NUM_BANKS;

  logic [7:0]           mem_r [NUM_BANKS][ROWS];
  logic [7:0]           q_r   [NUM_BANKS];
  logic [1:0]           off_r;
  logic                 word_r;

  logic [1:0]           off;
  logic [RW-1:0]        row;
  logic [RW-1:0]        bank_row [NUM_BANKS];
  logic [7:0]           bank_wd  [NUM_BANKS];
  logic [NUM_BANKS-1:0] bank_we;
  logic [31:0]          word_rd;

  assign off = req.addr[1:0];
  assign row = req.addr[AW-1:2];

  // banks below the start offset belong to the next row (wraps at the top)
  always_comb begin
    for (int j = 0; j < NUM_BANKS; j++) begin
      bank_row[j] = (2'(j) < off) ? RW'(row + 1'b1) : row;
      bank_wd[j]  = req.word ? req.wdata[{~(2'(j) - off), 3'b000} +: 8] : req.wdata[7:0];
      bank_we[j]  = req.wr && (req.word || (2'(j) == off));
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < NUM_BANKS; j++) begin
      if (bank_we[j]) begin
        mem_r[j][bank_row[j]] <= bank_wd[j];
      end
      if (req.rd) begin
        q_r[j] <= mem_r[j][bank_row[j]];
      end
    end
    if (req.rd) begin
      off_r  <= off;
      word_r <= req.word;
    end
  end

  // big-endian: lowest address lands in the top byte
  always_comb begin
    for (int k = 0; k < NUM_BANKS; k++) begin
      word_rd[8*(3-k) +: 8] = q_r[2'(off_r + 2'(k))];
    end
  end

  assign rdata = word_r ? word_rd : {24'b0, q_r[off_r]};

endmodule

FILE: rtl/dlx_instruction_execute.sv
// Executes one decoded DLX integer instruction per request against a 32-entry
// register file (R0 reads zero), a byte memory of MEM_BYTES bytes (a power of
// two; loads and stores are big-endian words or zero-extended bytes, each byte
// wrapping on its own), a PC_BITS-wide pc and a halt flag; once HALT executes,
// later requests come back with the pc unchanged and halted set. Each request
// yields exactly one response through the execute and result registers, and
// one request is taken per cycle unless the execute stage stalls; a request
// reading the register loaded by the request just ahead waits while that load
// is in write-back (memory reads are registered). The byte memory is not
// cleared: a byte must be stored before it is loaded. No clearing pass runs
// after reset; the register file comes up zero through per-entry valid bits.
`timescale 1ns / 1ps
`include "dlx_instruction_execute_assert.svh"

module dlx_instruction_execute
  import dlxe_pkg::*;
#(
  parameter int unsigned MEM_BYTES = 4096,
  parameter int unsigned PC_BITS   = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // instruction requests
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // op[5:0], rd[10:6], rs1[15:11], rs2[20:16], imm[52:21], target[68:53], zero[71:69]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // target_valid[0]
  input  logic [0:0]             in_tuser,
  // results
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // next_pc[15:0], out_value[47:16], halted[48], zero[55:49]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // out_valid[0]
  output logic [0:0]             out_tuser
);

  // ---------------------------------------------------------------------------
  // request fields
  // ---------------------------------------------------------------------------
  op_t         in_op;
  logic [4:0]  in_rd;
  logic [4:0]  in_rs1;
  logic [4:0]  in_rs2;
  logic [31:0] in_imm;
  logic [15:0] in_tgt;
  logic        in_acc;
  logic        in_rr;
  logic [4:0]  in_bsel;

  assign in_op  = in_tdata[5:0];
  assign in_rd  = in_tdata[10:6];
  assign in_rs1 = in_tdata[15:11];
  assign in_rs2 = in_tdata[20:16];
  assign in_imm = in_tdata[52:21];
  assign in_tgt = in_tdata[68:53];
  assign in_acc = in_tvalid && in_tready;

  // register-register ops read rs2 on port b, everything else reads rd there
  assign in_rr   = (in_op >= OP_ADD) && (in_op <= OP_SGE);
  assign in_bsel = in_rr ? in_rs2 : in_rd;

  // ---------------------------------------------------------------------------
  // state
  // ---------------------------------------------------------------------------
  logic [31:0]         rf_mem_r [NUM_REGS];
  logic [NUM_REGS-1:0] rf_vld_r;
  logic [31:0]         rf_qa_r;
  logic [31:0]         rf_qb_r;
  logic                rf_va_r;
  logic                rf_vb_r;

  logic [PC_BITS-1:0]  pc_r;
  logic [PC_BITS-1:0]  pc_nxt;
  logic                halt_r;
  logic                halt_nxt;

  // execute stage
  logic                s1_v_r;
  logic                s1_fresh_r;
  op_t                 s1_op_r;
  logic [4:0]          s1_rd_r;
  logic [4:0]          s1_rs1_r;
  logic [4:0]          s1_bsel_r;
  logic [31:0]         s1_imm_r;
  logic                s1_tv_r;
  logic [15:0]         s1_tgt_r;
  logic [31:0]         s1_a_r;
  logic [31:0]         s1_b_r;

  // write-back stage
  logic                s2_v_r;
  logic                s2_load_r;
  logic [4:0]          s2_rd_r;
  logic [31:0]         s2_val_r;

  // last register written, missed by a read issued on the same edge
  logic                w_v_r;
  logic [4:0]          w_rd_r;
  logic [31:0]         w_val_r;

  // result register
  logic                out_v_r;
  logic [15:0]         out_npc_r;
  logic                out_ov_r;
  logic [31:0]         out_val_r;
  logic                out_halt_r;

  logic [31:0]         a_base;
  logic [31:0]         b_base;
  logic [31:0]         a_cur;
  logic [31:0]         b_cur;
  logic                lu_stall;
  logic                s1_fire;
  logic [31:0]         wb_val;
  logic [31:0]         mem_rdata;

  logic                wb_en;
  logic                wb_load;
  logic [31:0]         alu_res;
  logic                ov_nxt;
  logic [31:0]         oval_nxt;
  mem_req_t            exe_req;
  mem_req_t            mem_req;

  // ---------------------------------------------------------------------------
  // register file: read on request, written from write-back
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rf_qa_r <= rf_mem_r[in_rs1];
      rf_qb_r <= rf_mem_r[in_bsel];
      rf_va_r <= rf_vld_r[in_rs1];
      rf_vb_r <= rf_vld_r[in_bsel];
    end
    if (s2_v_r) begin
      rf_mem_r[s2_rd_r] <= wb_val;
    end
  end

  // an entry never written reads as zero; r0 is never written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
    end else if (s2_v_r) begin
      rf_vld_r[s2_rd_r] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // operand forwarding: write-back stage first, then last write, then the
  // fresh read or the held operand while the stage waits
  // ---------------------------------------------------------------------------
  assign a_base = s1_fresh_r ? (rf_va_r ? rf_qa_r : '0) : s1_a_r;
  assign b_base = s1_fresh_r ? (rf_vb_r ? rf_qb_r : '0) : s1_b_r;

  always_comb begin
    if (s2_v_r && !s2_load_r && (s2_rd_r == s1_rs1_r)) begin
      a_cur = s2_val_r;
    end else if (w_v_r && (w_rd_r == s1_rs1_r)) begin
      a_cur = w_val_r;
    end else begin
      a_cur = a_base;
    end
    if (s2_v_r && !s2_load_r && (s2_rd_r == s1_bsel_r)) begin
      b_cur = s2_val_r;
    end else if (w_v_r && (w_rd_r == s1_bsel_r)) begin
      b_cur = w_val_r;
    end else begin
      b_cur = b_base;
    end
  end

  // load data is not ready until write-back, so a dependent op waits while the load is there
  assign lu_stall = s2_v_r && s2_load_r &&
                    ((s2_rd_r == s1_rs1_r) || (s2_rd_r == s1_bsel_r));
  assign s1_fire  = s1_v_r && !lu_stall && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || s1_fire;

  // ---------------------------------------------------------------------------
  // alu
  // ---------------------------------------------------------------------------
  logic [31:0] opnd2;
  logic        cmp_lt;
  logic        cmp_eq;

  assign opnd2  = (s1_op_r <= OP_SRLI) ? s1_imm_r : b_cur;
  assign cmp_lt = $signed(a_cur) < $signed(opnd2);
  assign cmp_eq = a_cur == opnd2;

  always_comb begin
    case (s1_op_r) inside
      OP_ADDI, OP_ADD: alu_res = a_cur + opnd2;
      OP_SUBI, OP_SUB: alu_res = a_cur - opnd2;
      OP_ANDI, OP_AND: alu_res = a_cur & opnd2;
      OP_ORI,  OP_OR:  alu_res = a_cur | opnd2;
      OP_XORI, OP_XOR: alu_res = a_cur ^ opnd2;
      OP_SGEI, OP_SGE: alu_res = {31'b0, !cmp_lt};
      OP_SEQI, OP_SEQ: alu_res = {31'b0, cmp_eq};
      OP_SNEI, OP_SNE: alu_res = {31'b0, !cmp_eq};
      OP_SLTI, OP_SLT: alu_res = {31'b0, cmp_lt};
      OP_SGTI, OP_SGT: alu_res = {31'b0, !cmp_lt && !cmp_eq};
      OP_SLEI, OP_SLE: alu_res = {31'b0, cmp_lt || cmp_eq};
      OP_SLLI:         alu_res = a_cur << s1_imm_r[4:0];
      OP_SRLI:         alu_res = a_cur >> s1_imm_r[4:0];
      default:         alu_res = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // decode and next pc
  // ---------------------------------------------------------------------------
  logic [PC_BITS-1:0] tgt_pc;
  logic [PC_BITS-1:0] br_pc;

  assign tgt_pc = PC_BITS'(s1_tgt_r);
  assign br_pc  = s1_tv_r ? tgt_pc : PC_BITS'(pc_r + s1_imm_r[PC_BITS-1:0]);

  always_comb begin
    pc_nxt   = PC_BITS'(pc_r + 1'b1);
    halt_nxt = halt_r;
    wb_en    = 1'b0;
    wb_load  = 1'b0;
    ov_nxt   = 1'b0;
    oval_nxt = '0;
    exe_req  = '0;
    exe_req.addr  = a_cur + s1_imm_r;
    exe_req.wdata = b_cur;
    if (halt_r) begin
      pc_nxt = pc_r;
    end else begin
      unique case (s1_op_r) inside
        OP_LW: begin
          exe_req.rd   = 1'b1;
          exe_req.word = 1'b1;
          wb_en        = 1'b1;
          wb_load      = 1'b1;
        end
        OP_SW: begin
          exe_req.wr   = 1'b1;
          exe_req.word = 1'b1;
        end
        OP_LB: begin
          exe_req.rd = 1'b1;
          wb_en      = 1'b1;
          wb_load    = 1'b1;
        end
        OP_SB: begin
          exe_req.wr = 1'b1;
        end
        OP_JR: begin
          pc_nxt = s1_tv_r ? tgt_pc : b_cur[PC_BITS-1:0];
        end
        OP_BEQZ, OP_BNEZ: begin
          if ((s1_op_r == OP_BEQZ) == (b_cur == '0)) begin
            pc_nxt = br_pc;
          end
        end
        [OP_ADDI:OP_SGE]: begin
          wb_en = 1'b1;
        end
        OP_HALT: begin
          halt_nxt = 1'b1;
          pc_nxt   = pc_r;
        end
        OP_OUT: begin
          ov_nxt   = 1'b1;
          oval_nxt = b_cur;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    mem_req    = exe_req;
    mem_req.rd = exe_req.rd && s1_fire;
    mem_req.wr = exe_req.wr && s1_fire;
  end

  dlxe_bmem #(
    .MEM_BYTES (MEM_BYTES)
  ) u_bmem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  // ---------------------------------------------------------------------------
  // pipeline registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      s1_fresh_r <= 1'b0;
      s2_v_r     <= 1'b0;
      w_v_r      <= 1'b0;
      out_v_r    <= 1'b0;
      pc_r       <= '0;
      halt_r     <= 1'b0;
    end else begin
      s1_fresh_r <= in_acc;
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_fire) begin
        s1_v_r <= 1'b0;
      end
      s2_v_r <= s1_fire && wb_en && (s1_rd_r != 5'd0);
      w_v_r  <= s2_v_r;
      if (s1_fire) begin
        out_v_r <= 1'b1;
        pc_r    <= pc_nxt;
        halt_r  <= halt_nxt;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign wb_val = s2_load_r ? mem_rdata : s2_val_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r   <= in_op;
      s1_rd_r   <= in_rd;
      s1_rs1_r  <= in_rs1;
      s1_bsel_r <= in_bsel;
      s1_imm_r  <= in_imm;
      s1_tv_r   <= in_tuser[0];
      s1_tgt_r  <= in_tgt;
    end
    // operands keep picking up older writes while the stage waits
    if (s1_v_r) begin
      s1_a_r <= a_cur;
      s1_b_r <= b_cur;
    end
    if (s1_fire) begin
      s2_load_r  <= wb_load;
      s2_rd_r    <= s1_rd_r;
      s2_val_r   <= alu_res;
      out_npc_r  <= 16'(pc_nxt);
      out_ov_r   <= ov_nxt;
      out_val_r  <= oval_nxt;
      out_halt_r <= halt_nxt;
    end
    w_rd_r  <= s2_rd_r;
    w_val_r <= wb_val;
  end

  // ---------------------------------------------------------------------------
  // result channel
  // ---------------------------------------------------------------------------
  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'b0, out_halt_r, out_val_r, out_npc_r};
  assign out_tuser  = out_ov_r;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  `DLXE_ASSERT_NEXT(a_halt_sticky, halt_r, halt_r, "halt flag cleared after halt")
  `DLXE_ASSERT_NEXT(a_halt_pc_hold, halt_r, pc_r == $past(pc_r), "pc moved while halted")
  `DLXE_ASSERT_NEXT(a_halt_no_wb, s1_fire && halt_r, !s2_v_r, "register write while halted")
  `DLXE_ASSERT_NOW(a_no_r0_write, s2_v_r, s2_rd_r != 5'd0, "write-back to r0")
  `DLXE_ASSERT_NOW(a_load_use, s1_v_r && lu_stall, !s1_fire, "op issued on pending load")

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import dlxe_pkg::*;

  localparam int unsigned MEM_BYTES    = 4096;
  localparam int unsigned PC_BITS      = 16;
  localparam int          RANDOM_ITEMS = 1725;
  localparam int          STALL_LIMIT  = 500;
  localparam int          DRAIN_CYCLES = 8;

  // opcodes past OUT do nothing but advance the pc
  localparam op_t OP_NOP_FIRST = 6'd33;
  localparam op_t OP_NOP_LAST  = 6'd39;

  // one decoded instruction request
  typedef struct {
    op_t         op;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [31:0] imm;
    logic        tv;
    logic [15:0] target;
  } instr_t;

  // one response
  typedef struct {
    logic [15:0] next_pc;
    logic        ovalid;
    logic [31:0] oval;
    logic        halted;
  } exec_result_t;

  // architectural state of the execute unit plus the responses still owed
  class exec_scoreboard;
    logic [31:0]  regs [NUM_REGS];
    logic [7:0]   mem [MEM_BYTES];
    bit           byte_written [MEM_BYTES];
    int unsigned  written_bytes [$];
    int unsigned  word_starts [$];
    logic [15:0]  pc;
    bit           halted;
    exec_result_t pending_results [$];
    int           errors;
    int           checked;
    int           outs_seen;
    int           taken;

    function new();
      foreach (regs[k]) regs[k] = '0;
      foreach (byte_written[k]) byte_written[k] = 1'b0;
      pc = '0;
      halted = 1'b0;
      errors = 0;
      checked = 0;
      outs_seen = 0;
      taken = 0;
    endfunction

    function void store_byte(logic [31:0] ea, logic [7:0] v);
      int unsigned idx;
      idx = ea % MEM_BYTES;
      mem[idx] = v;
      if (!byte_written[idx]) begin
        byte_written[idx] = 1'b1;
        written_bytes.push_back(idx);
      end
    endfunction

    function logic signed_compare(op_t op, logic [31:0] a, logic [31:0] b);
      case (op)
        OP_SGEI, OP_SGE: return $signed(a) >= $signed(b);
        OP_SEQI, OP_SEQ: return $signed(a) == $signed(b);
        OP_SNEI, OP_SNE: return $signed(a) != $signed(b);
        OP_SLTI, OP_SLT: return $signed(a) < $signed(b);
        OP_SGTI, OP_SGT: return $signed(a) > $signed(b);
        default:         return $signed(a) <= $signed(b);
      endcase
    endfunction

    function exec_result_t execute_instr(instr_t i);
      exec_result_t r;
      logic [31:0]  a, b, d, ea, val;
      logic [15:0]  nxt;
      bit           wb;
      a = regs[i.rs1];
      b = regs[i.rs2];
      d = regs[i.rd];
      ea = a + i.imm;
      nxt = pc + 16'd1;
      val = '0;
      wb = 1'b0;
      r.ovalid = 1'b0;
      r.oval = '0;
      if (halted) begin
        nxt = pc;
      end else begin
        case (i.op)
          OP_LW: begin
            for (int k = 0; k < 4; k++) val = {val[23:0], mem[(ea + k) % MEM_BYTES]};
            wb = 1'b1;
          end
          OP_SW: begin
            for (int k = 0; k < 4; k++) store_byte(ea + k, d[31 - 8 * k -: 8]);
            word_starts.push_back(ea % MEM_BYTES);
          end
          OP_LB: begin
            val = {24'b0, mem[ea % MEM_BYTES]};
            wb = 1'b1;
          end
          OP_SB: store_byte(ea, d[7:0]);
          OP_JR: begin
            nxt = i.tv ? i.target : d[15:0];
            taken++;
          end
          OP_BEQZ, OP_BNEZ: begin
            if ((i.op == OP_BEQZ) == (d == 32'd0)) begin
              nxt = i.tv ? i.target : pc + i.imm[15:0];
              taken++;
            end
          end
          OP_ADDI: begin val = a + i.imm; wb = 1'b1; end
          OP_SUBI: begin val = a - i.imm; wb = 1'b1; end
          OP_ANDI: begin val = a & i.imm; wb = 1'b1; end
          OP_ORI:  begin val = a | i.imm; wb = 1'b1; end
          OP_XORI: begin val = a ^ i.imm; wb = 1'b1; end
          OP_SGEI, OP_SEQI, OP_SNEI, OP_SLTI, OP_SGTI, OP_SLEI: begin
            val = {31'b0, signed_compare(i.op, a, i.imm)};
            wb = 1'b1;
          end
          OP_SLLI: begin val = a << i.imm[4:0]; wb = 1'b1; end
          OP_SRLI: begin val = a >> i.imm[4:0]; wb = 1'b1; end
          OP_ADD:  begin val = a + b; wb = 1'b1; end
          OP_SUB:  begin val = a - b; wb = 1'b1; end
          OP_AND:  begin val = a & b; wb = 1'b1; end
          OP_OR:   begin val = a | b; wb = 1'b1; end
          OP_XOR:  begin val = a ^ b; wb = 1'b1; end
          OP_SEQ, OP_SNE, OP_SLT, OP_SGT, OP_SLE, OP_SGE: begin
            val = {31'b0, signed_compare(i.op, a, b)};
            wb = 1'b1;
          end
          OP_HALT: begin
            halted = 1'b1;
            nxt = pc;
          end
          OP_OUT: begin
            r.ovalid = 1'b1;
            r.oval = d;
          end
          default: ;
        endcase
      end
      if (wb && i.rd != 5'd0) regs[i.rd] = val;
      pc = nxt;
      r.next_pc = pc;
      r.halted = halted;
      return r;
    endfunction

    function void note_request(instr_t i);
      pending_results.push_back(execute_instr(i));
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(exec_result_t got);
      exec_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected response, expected none, actual next_pc %h",
                 $time, got.next_pc);
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (got.ovalid) outs_seen++;
      compare_field("next_pc", want.next_pc, got.next_pc);
      compare_field("out_valid", want.ovalid, got.ovalid);
      compare_field("out_value", want.oval, got.oval);
      compare_field("halted", want.halted, got.halted);
    endfunction
  endclass

  // clock, reset and the block's ports, all known from time zero
  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [0:0]             in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [0:0]             out_tuser;

  exec_scoreboard sb;
  exec_result_t   rx_result;
  int             sent = 0;
  int             directed = 0;
  int             rx_wait = 0;
  int             idle_cycles = 0;
  bit             tx_burst = 1'b0;
  bit             rx_burst = 1'b0;
  // register most recently written, so that OUT and branches can observe it
  logic [4:0]     last_rd = 5'd1;

  always #5 clk = ~clk;

  dlx_instruction_execute #(
    .MEM_BYTES(MEM_BYTES),
    .PC_BITS  (PC_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  function automatic instr_t mk(op_t op, logic [4:0] rd, logic [4:0] rs1, logic [4:0] rs2,
                                logic [31:0] imm, logic tv = 1'b0,
                                logic [15:0] target = 16'h0);
    instr_t i;
    i.op = op;
    i.rd = rd;
    i.rs1 = rs1;
    i.rs2 = rs2;
    i.imm = imm;
    i.tv = tv;
    i.target = target;
    return i;
  endfunction

  // immediates lean toward the extremes and small signed offsets
  function automatic logic [31:0] rand_imm();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       return 32'h0000_0000;
          1:       return 32'h0000_0001;
          2:       return 32'hffff_ffff;
          3:       return 32'h7fff_ffff;
          default: return 32'h8000_0000;
        endcase
      end
      1, 2, 3: return 32'($urandom_range(0, 63)) - 32'd32;
      default: return $urandom();
    endcase
  endfunction

  // mostly write-then-observe chains; loads only ever aim at stored bytes
  function automatic instr_t rand_instr();
    instr_t      i;
    int unsigned pick;
    int unsigned addr;
    i = mk(OP_ADDI, 5'($urandom()), $urandom_range(0, 1) ? last_rd : 5'($urandom()),
           5'($urandom()), rand_imm(), 1'($urandom()), 16'($urandom()));
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      i.op = OP_OUT;
      if ($urandom_range(0, 2) != 0) i.rd = last_rd;
    end else if (pick < 42) begin
      i.op = op_t'($urandom_range(OP_ADDI, OP_SRLI));
    end else if (pick < 58) begin
      i.op = op_t'($urandom_range(OP_ADD, OP_SGE));
    end else if (pick < 68) begin
      i.op = $urandom_range(0, 1) ? OP_SW : OP_SB;
    end else if (pick < 80 && sb.written_bytes.size() != 0) begin
      if (sb.word_starts.size() != 0 && $urandom_range(0, 1) == 1) begin
        i.op = OP_LW;
        addr = sb.word_starts[$urandom_range(0, sb.word_starts.size() - 1)];
      end else begin
        i.op = OP_LB;
        addr = sb.written_bytes[$urandom_range(0, sb.written_bytes.size() - 1)];
      end
      // random upper address bits, low bits land on the chosen byte
      i.imm = (($urandom() & ~32'(MEM_BYTES - 1)) | addr) - sb.regs[i.rs1];
    end else if (pick < 94) begin
      i.op = op_t'($urandom_range(OP_JR, OP_BNEZ));
      if ($urandom_range(0, 1) == 1) i.rd = last_rd;
    end else begin
      i.op = op_t'($urandom_range(OP_NOP_FIRST, OP_NOP_LAST));
    end
    if (i.op inside {OP_LW, OP_LB, [OP_ADDI:OP_SGE]}) last_rd = i.rd;
    return i;
  endfunction

  // present one request after a random gap and hold it until taken
  task automatic send_instr(input instr_t i);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    // zero pad, target, imm, rs2, rs1, rd, op from the top down
    in_tdata <= {3'b000, i.target, i.imm, i.rs2, i.rs1, i.rd, i.op};
    in_tuser <= i.tv;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(i);
    sent++;
    // now and then switch between gapped and back-to-back requests
    if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
  endtask

  // result side: check on every accepted response, then hold off ready while rx_wait counts down
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_wait = 0;
    end else if (out_tvalid && out_tready) begin
      rx_result.next_pc = out_tdata[15:0];
      rx_result.oval = out_tdata[47:16];
      rx_result.halted = out_tdata[48];
      rx_result.ovalid = out_tuser[0];
      sb.check_result(rx_result);
      rx_wait = rx_burst ? 0 : $urandom_range(0, 7);
      if (rx_wait != 0) out_tready <= 1'b0;
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
    end else if (!out_tready) begin
      if (rx_wait <= 1) out_tready <= 1'b1;
      if (rx_wait != 0) rx_wait = rx_wait - 1;
    end
  end

  // watchdog: too long without any request or response moving
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, nothing moved for %0d cycles", $time, idle_cycles);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: operand extremes, r0 writes, signed compares, shift amounts
    send_instr(mk(OP_ADDI, 5'd1, 5'd0, 5'd0, 32'h7fff_ffff));
    send_instr(mk(OP_OUT, 5'd1, 5'd0, 5'd0, 32'h0));
    send_instr(mk(OP_ADDI, 5'd2, 5'd0, 5'd0, 32'h8000_0000));
    send_instr(mk(OP_ADDI, 5'd0, 5'd1, 5'd0, 32'd5));
    send_instr(mk(OP_OUT, 5'd0, 5'd0, 5'd0, 32'h0));
    send_instr(mk(OP_SLTI, 5'd3, 5'd2, 5'd0, 32'h7fff_ffff));
    send_instr(mk(OP_SGT, 5'd4, 5'd1, 5'd2, 32'h0));
    // only the low five bits of the shift amount count, SRLI is logical
    send_instr(mk(OP_SLLI, 5'd5, 5'd1, 5'd0, 32'd33));
    send_instr(mk(OP_SRLI, 5'd6, 5'd2, 5'd0, 32'hffff_ffff));
    send_instr(mk(OP_OUT, 5'd6, 5'd0, 5'd0, 32'h0));
    // word store and load that wrap past the top of memory
    send_instr(mk(OP_SW, 5'd2, 5'd0, 5'd0, 32'(MEM_BYTES - 2)));
    send_instr(mk(OP_LW, 5'd7, 5'd0, 5'd0, 32'hffff_fffe));
    send_instr(mk(OP_OUT, 5'd7, 5'd0, 5'd0, 32'h0));
    // byte load comes back zero-extended
    send_instr(mk(OP_SB, 5'd1, 5'd0, 5'd0, 32'd100));
    send_instr(mk(OP_LB, 5'd8, 5'd0, 5'd0, 32'd100));
    send_instr(mk(OP_OUT, 5'd8, 5'd0, 5'd0, 32'h0));
    // relative branch below zero, label branches taken and not, both jumps
    send_instr(mk(OP_BEQZ, 5'd0, 5'd0, 5'd0, -32'sd100));
    send_instr(mk(OP_BNEZ, 5'd1, 5'd0, 5'd0, 32'h0, 1'b1, 16'hffff));
    send_instr(mk(OP_BEQZ, 5'd1, 5'd0, 5'd0, 32'h0, 1'b1, 16'h1234));
    send_instr(mk(OP_JR, 5'd5, 5'd0, 5'd0, 32'h0));
    send_instr(mk(OP_JR, 5'd0, 5'd0, 5'd0, 32'h0, 1'b1, 16'h1234));
    send_instr(mk(OP_SUB, 5'd9, 5'd2, 5'd1, 32'h0));
    send_instr(mk(OP_OUT, 5'd9, 5'd0, 5'd0, 32'h0));
    send_instr(mk(OP_NOP_FIRST, 5'd31, 5'd31, 5'd31, 32'hffff_ffff, 1'b1, 16'hffff));
    send_instr(mk(OP_NOP_LAST, 5'd0, 5'd0, 5'd0, 32'h0));
    directed = sent;

    // random instruction stream
    repeat (RANDOM_ITEMS) send_instr(rand_instr());

    // halt, then a few requests that must be ignored
    send_instr(mk(OP_HALT, 5'($urandom()), 5'($urandom()), 5'($urandom()), $urandom()));
    repeat (4) send_instr(rand_instr());
    in_tvalid <= 1'b0;

    // let the last responses come back, then let the bench idle before finishing
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d instructions (%0d directed, halt near the end), %0d responses checked",
             sent, directed, sb.checked);
    $display("%0d output values seen, %0d jumps or branches taken, %0d memory bytes written",
             sb.outs_seen, sb.taken, sb.written_bytes.size());
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
